/* sv/mws_pkg.sv */
// Shared types, constants and helpers for the moving window statistics block.
`timescale 1ns / 1ps

package mws_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;

  localparam int PTR_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W     = SAMPLE_BITS + PTR_W;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);
  localparam int TRIAL_W   = PTR_W + 1;

  localparam int MODE_W    = 2;
  localparam int WLEN_W    = 7;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(1);

  localparam logic [MODE_W-1:0] MODE_MEAN = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_MAX  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_MIN  = MODE_W'(2);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic walk;
    logic div_start;
    logic div_run;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  // Clamp the programmed window length into 1..WINDOW_MAX.
  function automatic logic [CNT_W-1:0] eff_len(input logic [WLEN_W-1:0] wl);
    logic [CNT_W-1:0] len;
    if (wl == '0) begin
      len = CNT_W'(1);
    end else if (32'(wl) > WINDOW_MAX) begin
      len = CNT_W'(WINDOW_MAX);
    end else begin
      len = CNT_W'(wl);
    end
    return len;
  endfunction

endpackage

/* sv/mws_ifs.sv */
// Handshake channel interfaces for samples, results and register writes.
`timescale 1ns / 1ps

interface mws_in_if;
  import mws_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_of_series;
  modport source (output valid, sample, last_of_series, input ready);
  modport sink (input valid, sample, last_of_series, output ready);
endinterface

interface mws_out_if;
  import mws_pkg::*;
  logic    valid;
  logic    ready;
  sample_t value;
  logic    valid_res;
  logic    last_out;
  modport source (output valid, value, valid_res, last_out, input ready);
  modport sink (input valid, value, valid_res, last_out, output ready);
endinterface

interface mws_cfg_if;
  import mws_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/mws_ctrl.sv */
// Sequencer that steps one item through store walk, divide and output.
`timescale 1ns / 1ps

module mws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mws_pkg::dp_stat_t   stat,
  output mws_pkg::ctrl_cmd_t  cmd
);
  import mws_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (stat.walk_done) state_nxt = stat.need_div ? ST_DIV_LOAD : ST_OUT;
      end
      ST_DIV_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_WALK:     cmd.walk      = 1'b1;
      ST_DIV_LOAD: cmd.div_start = 1'b1;
      ST_DIV:      cmd.div_run   = 1'b1;
      ST_OUT:      cmd.load_out  = stat.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* sv/mws_dp.sv */
// Datapath: sample store, window walk accumulator, serial divider and output register.
`timescale 1ns / 1ps

module mws_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mws_pkg::ctrl_cmd_t           cmd,
  output mws_pkg::dp_stat_t            stat,
  input  mws_pkg::sample_t             in_sample,
  input  logic                         in_last,
  input  logic [mws_pkg::MODE_W-1:0]   mode,
  input  logic [mws_pkg::WLEN_W-1:0]   window_len,
  input  logic                         out_ready,
  output logic                         out_valid,
  output mws_pkg::sample_t             out_value,
  output logic                         out_valid_res,
  output logic                         out_last
);
  import mws_pkg::*;

  sample_t mem [WINDOW_MAX];

  logic [PTR_W-1:0]     write_pos_r;
  logic [CNT_W-1:0]     fill_r;
  logic [PTR_W-1:0]     newest_r;
  logic [CNT_W-1:0]     len_r;
  logic [CNT_W-1:0]     k_r;
  logic                 rd_pend_r;
  sample_t              rd_data_r;
  sum_t                 acc_r;
  logic                 valid_r;
  logic                 last_r;
  logic                 neg_r;
  logic [SUM_W-1:0]     quot_r;
  logic [PTR_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 out_v_r;
  sample_t              out_value_r;
  logic                 out_valid_res_r;
  logic                 out_last_r;

  logic [CNT_W-1:0]   len_eff;
  logic [CNT_W-1:0]   fill_inc;
  logic               full_now;
  logic               mode_mean;
  logic               rd_en;
  logic [CNT_W:0]     addr_wide;
  logic [PTR_W-1:0]   rd_addr;
  sum_t               elem;
  sum_t               acc_step;
  logic [TRIAL_W-1:0] trial;
  logic               qbit;
  logic [SUM_W-1:0]   quot_signed;
  sample_t            value_fin;

  assign len_eff   = eff_len(window_len);
  assign fill_inc  = (32'(fill_r) < WINDOW_MAX) ? fill_r + CNT_W'(1) : fill_r;
  assign full_now  = fill_inc >= len_eff;
  assign mode_mean = !((mode == MODE_MAX) || (mode == MODE_MIN));

  // Walk back from the newest entry, wrapping around the circular store.
  assign rd_en     = cmd.walk && (k_r < len_r);
  assign addr_wide = ((CNT_W + 1)'(newest_r) >= (CNT_W + 1)'(k_r))
                   ? (CNT_W + 1)'(newest_r) - (CNT_W + 1)'(k_r)
                   : (CNT_W + 1)'(newest_r) + (CNT_W + 1)'(WINDOW_MAX) - (CNT_W + 1)'(k_r);
  assign rd_addr   = addr_wide[PTR_W-1:0];

  assign elem = {{PTR_W{rd_data_r[SAMPLE_BITS-1]}}, rd_data_r};

  always_comb begin
    case (mode)
      MODE_MAX: acc_step = (elem > acc_r) ? elem : acc_r;
      MODE_MIN: acc_step = (elem < acc_r) ? elem : acc_r;
      default:  acc_step = acc_r + elem;
    endcase
  end

  assign trial = {rem_r, quot_r[SUM_W-1]};
  assign qbit  = trial >= TRIAL_W'(len_r);

  assign quot_signed = neg_r ? (~quot_r + SUM_W'(1)) : quot_r;

  always_comb begin
    if (!valid_r) begin
      value_fin = '0;
    end else if (mode_mean) begin
      value_fin = quot_signed[SAMPLE_BITS-1:0];
    end else begin
      value_fin = acc_r[SAMPLE_BITS-1:0];
    end
  end

  assign stat.walk_done = (k_r >= len_r) && !rd_pend_r;
  assign stat.need_div  = valid_r && mode_mean;
  assign stat.div_done  = div_cnt_r == '0;
  assign stat.out_free  = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) mem[write_pos_r] <= in_sample;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      rd_pend_r   <= 1'b0;
      div_cnt_r   <= '0;
      out_v_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        write_pos_r <= (32'(write_pos_r) == WINDOW_MAX - 1) ? '0 : write_pos_r + PTR_W'(1);
        fill_r      <= in_last ? '0 : fill_inc;
        // Skip the walk entirely when the window is not yet full.
        k_r         <= full_now ? CNT_W'(1) : len_eff;
      end else if (rd_en) begin
        k_r <= k_r + CNT_W'(1);
      end
      if (cmd.walk) begin
        rd_pend_r <= rd_en;
      end
      if (cmd.div_start) begin
        div_cnt_r <= DIV_CNT_W'(SUM_W);
      end else if (cmd.div_run && (div_cnt_r != '0)) begin
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      newest_r <= write_pos_r;
      len_r    <= len_eff;
      valid_r  <= full_now;
      last_r   <= in_last;
      acc_r    <= {{PTR_W{in_sample[SAMPLE_BITS-1]}}, in_sample};
    end else if (cmd.walk && rd_pend_r) begin
      acc_r <= acc_step;
    end
    if (cmd.div_start) begin
      neg_r  <= acc_r[SUM_W-1];
      quot_r <= acc_r[SUM_W-1] ? (~acc_r + SUM_W'(1)) : acc_r;
      rem_r  <= '0;
    end else if (cmd.div_run && (div_cnt_r != '0)) begin
      rem_r  <= qbit ? PTR_W'(trial - TRIAL_W'(len_r)) : trial[PTR_W-1:0];
      quot_r <= {quot_r[SUM_W-2:0], qbit};
    end
    if (cmd.load_out) begin
      out_value_r     <= value_fin;
      out_valid_res_r <= valid_r;
      out_last_r      <= last_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_value     = out_value_r;
  assign out_valid_res = out_valid_res_r;
  assign out_last      = out_last_r;

endmodule

/* sv/moving_window_statistics.sv */
// Top level: register file, sequencer and datapath of the moving window statistics block.
//
//   channel   dir   payload                              accepted when
//   in_ch     in    sample, last_of_series               valid && ready
//   out_ch    out   value, valid_res, last_out           valid && ready
//   cfg_ch    in    index (0 mode, 1 window_len), data   valid && ready (always ready)
//
// One item at a time: an accept, then the walk: len - 1 store reads through the
// single registered read port, then folding the last read and finishing (no reads
// when len is 1 or the window is not full), then for a mean over a full window a load
// and the bit-serial divider, then the output state.
// Reset is synchronous, active low; the sample store needs no clearing.
// A stalled output holds the result register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module moving_window_statistics (
  input logic        clk,
  input logic        rst_n,
  mws_in_if.sink     in_ch,
  mws_out_if.source  out_ch,
  mws_cfg_if.sink    cfg_ch
);
  import mws_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic [WLEN_W-1:0] wlen_r;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;

  assign cfg_ch.ready = 1'b1;

  // Drop writes to unknown register indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MEAN;
      wlen_r <= WLEN_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MODE:       mode_r <= cfg_ch.data[MODE_W-1:0];
        REG_WINDOW_LEN: wlen_r <= cfg_ch.data[WLEN_W-1:0];
        default: begin
          mode_r <= mode_r;
          wlen_r <= wlen_r;
        end
      endcase
    end
  end

  mws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mws_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_sample     (in_ch.sample),
    .in_last       (in_ch.last_of_series),
    .mode          (mode_r),
    .window_len    (wlen_r),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_value     (out_ch.value),
    .out_valid_res (out_ch.valid_res),
    .out_last      (out_ch.last_out)
  );

endmodule

/* test/window_stats_checker.sv */
// Predicts and checks every result of the moving window statistics block.
`timescale 1ns / 1ps

module window_stats_checker
  import mws_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mws_in_if    in_mon,
  mws_out_if   out_mon,
  mws_cfg_if   cfg_mon,
  output int   mismatches,
  output int   outstanding
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    sample_t value;
    logic    valid_res;
    logic    last_out;
  } stat_result_t;

  sample_t           window_mem [WINDOW_MAX];
  logic [PTR_W-1:0]  next_slot;
  logic [CNT_W-1:0]  series_fill;
  logic [MODE_W-1:0] stat_mode;
  logic [WLEN_W-1:0] len_reg;
  stat_result_t      pending_results [$];
  int                bad;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    bad         = 0;
  end

  // Length actually used: zero acts as one, oversized lengths clip to the store depth.
  function automatic int window_span();
    int span;
    if (len_reg == '0) begin
      span = 1;
    end else if (int'(len_reg) > WINDOW_MAX) begin
      span = WINDOW_MAX;
    end else begin
      span = int'(len_reg);
    end
    return span;
  endfunction

  // Store one sample and work out its mean, maximum or minimum over the window.
  function automatic stat_result_t absorb_sample(input sample_t s, input logic last);
    stat_result_t     r;
    logic [PTR_W-1:0] slot;
    int               span;
    int               k;
    longint           acc;
    sample_t          e;
    r = '0;
    span = window_span();
    slot = next_slot;
    window_mem[slot] = s;
    next_slot = slot + PTR_W'(1);
    if (series_fill < CNT_W'(WINDOW_MAX)) begin
      series_fill = series_fill + CNT_W'(1);
    end
    if (int'(series_fill) >= span) begin
      acc = longint'(s);
      for (k = 1; k < span; k++) begin
        // walk back from the newest entry, wrapping around the store
        e = window_mem[slot - PTR_W'(k)];
        case (stat_mode)
          MODE_MAX: begin
            if (longint'(e) > acc) acc = longint'(e);
          end
          MODE_MIN: begin
            if (longint'(e) < acc) acc = longint'(e);
          end
          default: begin
            acc = acc + longint'(e);
          end
        endcase
      end
      if (stat_mode != MODE_MAX && stat_mode != MODE_MIN) begin
        acc = acc / longint'(span);
      end
      r.value     = sample_t'(acc);
      r.valid_res = 1'b1;
    end
    r.last_out = last;
    if (last) begin
      series_fill = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    stat_result_t want;
    stat_result_t got;
    if (!rst_n) begin
      next_slot   = '0;
      series_fill = '0;
      stat_mode   = MODE_MEAN;
      len_reg     = WLEN_W'(1);
      pending_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_MODE) begin
          stat_mode = cfg_mon.data[MODE_W-1:0];
        end else if (cfg_mon.index == REG_WINDOW_LEN) begin
          len_reg = cfg_mon.data[WLEN_W-1:0];
        end
      end
      // push before pop: a result never belongs to the item taken on the same edge
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(absorb_sample(in_mon.sample, in_mon.last_of_series));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.value     = out_mon.value;
        got.valid_res = out_mon.valid_res;
        got.last_out  = out_mon.last_out;
        if (pending_results.size() == 0) begin
          bad++;
          if (bad <= REPORT_LIMIT) begin
            $display("%0t checker: unexpected result value %h valid_res %b last_out %b",
                     $realtime, got.value, got.valid_res, got.last_out);
          end
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            bad++;
            if (bad <= REPORT_LIMIT) begin
              $display({"%0t checker: expected value %h valid_res %b last_out %b,",
                        " got value %h valid_res %b last_out %b"},
                       $realtime, want.value, want.valid_res, want.last_out,
                       got.value, got.valid_res, got.last_out);
            end
          end
        end
      end
    end
    mismatches  <= bad;
    outstanding <= pending_results.size();
  end

endmodule

/* test/tb_top.sv */
// Stimulus, clock, reset and verdict for the moving window statistics block.
`timescale 1ns / 1ps

module tb_top;
  import mws_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TOTAL_ITEMS = 550;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 120;

  localparam logic [MODE_W-1:0] MODE_SPARE = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_SWEEP [4] = '{MODE_MEAN, MODE_MAX, MODE_MIN, MODE_SPARE};

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   items_sent;
  int   chk_fails;
  int   chk_waiting;
  bit   burst;
  bit   hold_results;

  mws_in_if  in_if ();
  mws_out_if out_if ();
  mws_cfg_if cfg_if ();

  moving_window_statistics dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  window_stats_checker stats_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_mon     (cfg_if),
    .mismatches  (chk_fails),
    .outstanding (chk_waiting)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic sample_t rand_sample();
    sample_t s;
    case ($urandom_range(0, 5))
      0: s = sample_t'(32'h7FFF_FFFF);
      1: s = sample_t'(32'h8000_0000);
      2: s = sample_t'($urandom_range(0, 200)) - sample_t'(100);
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  // Leave valid high across back-to-back items; lower it only for a gap.
  task automatic offer_sample(input sample_t s, input logic last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.sample         <= s;
    in_if.last_of_series <= last;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (chk_waiting != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic set_window(input logic [CFG_DAT_W-1:0] mode_val,
                            input logic [CFG_DAT_W-1:0] len_val, input bit junk);
    write_reg(REG_MODE, mode_val);
    // an unmapped index must leave both registers alone
    if (junk) write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DAT_W'($urandom));
    write_reg(REG_WINDOW_LEN, len_val);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_receiver
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        // hold off long enough for the block to back up and stall its input
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        stall = burst ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin : stimulus
    int                   phase;
    int                   span;
    int                   left;
    int                   series_len;
    int                   k;
    int                   r;
    logic [CFG_DAT_W-1:0] mode_val;
    logic [CFG_DAT_W-1:0] len_val;
    items_sent   = 0;
    burst        = 1'b0;
    hold_results = 1'b0;
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.sample         <= '0;
    in_if.last_of_series <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // mean at both extremes, then truncation of a negative sum
    set_window(CFG_DAT_W'(MODE_MEAN), CFG_DAT_W'(3), 1'b1);
    repeat (3) offer_sample(sample_t'(32'h7FFF_FFFF), 1'b0);
    repeat (3) offer_sample(sample_t'(32'h8000_0000), 1'b0);
    offer_sample(sample_t'(-1), 1'b1);
    drain_results();

    // zero length acts as one
    set_window(CFG_DAT_W'(MODE_MAX), CFG_DAT_W'(0), 1'b0);
    offer_sample(sample_t'(5), 1'b0);
    offer_sample(sample_t'(32'h8000_0000), 1'b1);
    drain_results();

    set_window(CFG_DAT_W'(MODE_MIN), CFG_DAT_W'(2), 1'b0);
    offer_sample(sample_t'(32'h7FFF_FFFF), 1'b0);
    offer_sample(sample_t'(32'h8000_0000), 1'b0);
    offer_sample(sample_t'(1), 1'b1);
    drain_results();

    // spare mode code with an oversized length: window never fills here
    set_window(CFG_DAT_W'(MODE_SPARE), CFG_DAT_W'(127), 1'b0);
    offer_sample(sample_t'(1), 1'b0);
    offer_sample(sample_t'(2), 1'b1);
    offer_sample(sample_t'(3), 1'b1);
    drain_results();

    set_window(CFG_DAT_W'(MODE_MEAN), CFG_DAT_W'(2), 1'b0);
    offer_sample(sample_t'(-3), 1'b0);
    offer_sample(sample_t'(0), 1'b1);
    offer_sample(sample_t'(3), 1'b0);
    offer_sample(sample_t'(0), 1'b1);
    drain_results();

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case (phase)
        0: len_val = CFG_DAT_W'(WINDOW_MAX);
        1: len_val = CFG_DAT_W'(1);
        2: len_val = CFG_DAT_W'(127);
        3: len_val = CFG_DAT_W'(0);
        default: begin
          r = $urandom_range(0, 9);
          if (r < 7) begin
            len_val = CFG_DAT_W'($urandom_range(1, 8));
          end else if (r == 7) begin
            len_val = CFG_DAT_W'($urandom_range(9, WINDOW_MAX - 1));
          end else if (r == 8) begin
            len_val = CFG_DAT_W'(WINDOW_MAX);
          end else begin
            len_val = ($urandom_range(0, 1) == 0) ? CFG_DAT_W'(0)
                                                  : CFG_DAT_W'($urandom_range(65, 127));
          end
        end
      endcase
      mode_val = (phase < 4) ? CFG_DAT_W'(MODE_SWEEP[phase]) : CFG_DAT_W'($urandom_range(0, 127));
      burst = (phase == 1) || ($urandom_range(0, 4) == 0);
      if (phase == 1) hold_results = 1'b1;
      set_window(mode_val, len_val, $urandom_range(0, 3) == 0);
      span = (len_val == '0) ? 1 : ((int'(len_val) > WINDOW_MAX) ? WINDOW_MAX : int'(len_val));
      left = span + $urandom_range(8, 40);
      while (left > 0) begin
        // mostly series long enough to fill the window, some cut short
        if ($urandom_range(0, 4) == 0) begin
          series_len = $urandom_range(1, span);
        end else begin
          series_len = span + $urandom_range(0, span + 8);
        end
        for (k = 0; k < series_len && left > 0; k++) begin
          offer_sample(rand_sample(), k == series_len - 1);
          left--;
          if ($urandom_range(0, 39) == 0) drain_results();
        end
      end
      drain_results();
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (chk_fails == 0 && chk_waiting == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
